@@ src/latency_window_statistics_defines.svh @@
// ----------------------------------------------------------------------------
// latency window statistics assertion macros
// concurrent checks on the top level ports, clocked by clk, off during reset
// ----------------------------------------------------------------------------
`ifndef LATENCY_WINDOW_STATISTICS_DEFINES_SVH
`define LATENCY_WINDOW_STATISTICS_DEFINES_SVH

// same-cycle implication
`define LWS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("latency window statistics check failed");

// next-cycle implication
`define LWS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("latency window statistics check failed");

`endif

@@ src/lwstat_pkg.sv @@
// ----------------------------------------------------------------------------
// lwstat_pkg
// shared types and constants of the latency window statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package lwstat_pkg;

	localparam int DIV_NW = 64;
	localparam int DIV_DW = 48;

	localparam logic [17:0] RATE_SCALE = 18'd256000;
	localparam logic [47:0] RATE_SAT   = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] COUNT_SAT  = 32'hFFFF_FFFF;

	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic DIV_SEL_MEAN = 1'b0;
	localparam logic DIV_SEL_RATE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REC_RD,
		ST_REC_UPD,
		ST_MEAN,
		ST_MEAN_WAIT,
		ST_RATE_MUL,
		ST_RATE,
		ST_RATE_WAIT,
		ST_SEL_K,
		ST_SEL_SCAN,
		ST_SEL_DRAIN,
		ST_SEL_BIT,
		ST_OUT
	} lwstat_state_t;

	typedef struct packed {
		logic capture;
		logic rd_wp;
		logic rec_update;
		logic div_start;
		logic div_sel;
		logic mean_store;
		logic rate_mul;
		logic rate_store;
		logic sel_init;
		logic scan_rd;
		logic sel_bit;
	} lwstat_cmd_t;

	typedef struct packed {
		logic req;
		logic len_zero;
		logic div_done;
		logic rate_div;
		logic scan_last;
		logic bit_zero;
	} lwstat_status_t;

endpackage

`default_nettype wire

@@ src/lwstat_ctrl.sv @@
// ----------------------------------------------------------------------------
// lwstat_ctrl
// sequencer for record update, mean and rate division and percentile select
// ----------------------------------------------------------------------------
`default_nettype none

module lwstat_ctrl import lwstat_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output logic                done,
	output lwstat_cmd_t         cmd,
	input  wire lwstat_status_t sts
);

	lwstat_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_REC_RD;
				end
			end
			ST_REC_RD: begin
				if (sts.req == REQ_QUERY) begin
					state_d = sts.len_zero ? ST_RATE_MUL : ST_MEAN;
				end else begin
					cmd.rd_wp = 1'b1;
					state_d = ST_REC_UPD;
				end
			end
			ST_REC_UPD: begin
				cmd.rec_update = 1'b1;
				state_d = ST_MEAN;
			end
			ST_MEAN: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_SEL_MEAN;
				state_d = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (sts.div_done) begin
					cmd.mean_store = 1'b1;
					state_d = ST_RATE_MUL;
				end
			end
			ST_RATE_MUL: begin
				cmd.rate_mul = 1'b1;
				if (sts.rate_div) begin
					state_d = ST_RATE;
				end else if (sts.req == REQ_QUERY && !sts.len_zero) begin
					state_d = ST_SEL_K;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_RATE: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_SEL_RATE;
				state_d = ST_RATE_WAIT;
			end
			ST_RATE_WAIT: begin
				if (sts.div_done) begin
					cmd.rate_store = 1'b1;
					if (sts.req == REQ_QUERY && !sts.len_zero) begin
						state_d = ST_SEL_K;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SEL_K: begin
				cmd.sel_init = 1'b1;
				state_d = ST_SEL_SCAN;
			end
			ST_SEL_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_SEL_DRAIN;
				end
			end
			ST_SEL_DRAIN: begin
				state_d = ST_SEL_BIT;
			end
			ST_SEL_BIT: begin
				cmd.sel_bit = 1'b1;
				state_d = sts.bit_zero ? ST_OUT : ST_SEL_SCAN;
			end
			ST_OUT: begin
				done = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/lwstat_div.sv @@
// ----------------------------------------------------------------------------
// lwstat_div
// restoring divider, one quotient bit per cycle, shared by mean and rate
// ----------------------------------------------------------------------------
`default_nettype none

module lwstat_div import lwstat_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] dividend,
	input  wire logic [DIV_DW-1:0] divisor,
	output logic      [DIV_NW-1:0] quotient,
	output logic                   done
);

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_NW-1:0] dvd_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW-1:0] rem_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW:0]   shifted;
	logic              ge;

	assign shifted = {rem_q, dvd_q[DIV_NW-1]};
	assign ge = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? DIV_DW'(shifted - {1'b0, dvs_q}) : shifted[DIV_DW-1:0];
			dvd_q <= {dvd_q[DIV_NW-2:0], ge};
		end
	end

	assign quotient = dvd_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ src/lwstat_dp.sv @@
// ----------------------------------------------------------------------------
// lwstat_dp
// sample ring, running statistics, divider operands and radix percentile select
// ----------------------------------------------------------------------------
`default_nettype none

module lwstat_dp import lwstat_pkg::*; #(
	parameter int WINDOW = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lwstat_cmd_t cmd,
	output lwstat_status_t   sts,
	input  wire logic        req_type,
	input  wire logic [31:0] sample_value,
	input  wire logic [47:0] now_ms,
	input  wire logic [16:0] ratio_q16,
	output logic      [31:0] min_value,
	output logic      [31:0] max_value,
	output logic             stats_valid,
	output logic      [31:0] sample_count,
	output logic      [39:0] mean_q8,
	output logic      [31:0] percentile_value,
	output logic             window_empty,
	output logic      [47:0] rate_q8
);

	localparam int AW   = $clog2(WINDOW);
	localparam int LW   = $clog2(WINDOW + 1);
	localparam int SUMW = 32 + AW;
	localparam int KPW  = 17 + LW;

	logic [31:0] mem [WINDOW];
	logic [31:0] rdata_q;
	logic [AW-1:0] rd_addr;

	logic        req_q;
	logic [31:0] val_q;
	logic [47:0] now_q;
	logic [16:0] ratio_q;

	logic [AW-1:0]   wp_q;
	logic [LW-1:0]   fill_q;
	logic [SUMW-1:0] sum_q;
	logic [31:0]     count_q;
	logic [31:0]     min_q;
	logic [31:0]     max_q;
	logic            any_q;
	logic [47:0]     first_q;
	logic [47:0]     last_q;

	logic [39:0] mean_q;
	logic [47:0] rate_q;
	logic [31:0] pct_q;
	logic [49:0] num_q;

	logic [AW-1:0] scan_addr_q;
	logic          scan_v_q;
	logic [LW-1:0] cnt0_q;
	logic [LW-1:0] k_q;
	logic [31:0]   prefix_q;
	logic [31:0]   mask_q;
	logic [4:0]    bit_q;

	logic              full;
	logic [47:0]       span;
	logic [DIV_NW-1:0] div_dividend;
	logic [DIV_DW-1:0] div_divisor;
	logic [DIV_NW-1:0] div_quot;
	logic              div_done;
	logic [KPW-1:0]    kprod;
	logic [LW:0]       kraw;
	logic [LW-1:0]     kclamp;
	logic              match;
	logic              take_one;
	logic [31:0]       prefix_next;

	assign full = fill_q == LW'(WINDOW);
	assign span = last_q - first_q;

	assign rd_addr = cmd.rd_wp ? wp_q : scan_addr_q;

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (cmd.rec_update) begin
			mem[wp_q] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			val_q <= sample_value;
			now_q <= now_ms;
			ratio_q <= ratio_q16;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
			count_q <= '0;
			min_q <= '0;
			max_q <= '0;
			any_q <= 1'b0;
			first_q <= '0;
			last_q <= '0;
		end else if (cmd.rec_update) begin
			if (!any_q) begin
				first_q <= now_q;
				min_q <= val_q;
				max_q <= val_q;
				any_q <= 1'b1;
			end else begin
				if (val_q < min_q) min_q <= val_q;
				if (val_q > max_q) max_q <= val_q;
			end
			last_q <= now_q;
			if (count_q != COUNT_SAT) count_q <= count_q + 1'b1;
			if (full) begin
				sum_q <= sum_q - SUMW'(rdata_q) + SUMW'(val_q);
			end else begin
				sum_q <= sum_q + SUMW'(val_q);
				fill_q <= fill_q + 1'b1;
			end
			wp_q <= (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
		end
	end

	// shared divider operands
	assign div_dividend = (cmd.div_sel == DIV_SEL_MEAN) ?
		DIV_NW'({sum_q, 8'd0}) : DIV_NW'(num_q);
	assign div_divisor = (cmd.div_sel == DIV_SEL_MEAN) ? DIV_DW'(fill_q) : span;

	lwstat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	// percentile rank
	assign kprod = KPW'(ratio_q) * KPW'(fill_q);
	assign kraw = kprod[KPW-1:16];
	always_comb begin
		if (kraw == '0) begin
			kclamp = LW'(1);
		end else if (kraw > {1'b0, fill_q}) begin
			kclamp = fill_q;
		end else begin
			kclamp = kraw[LW-1:0];
		end
	end

	assign match = (((rdata_q ^ prefix_q) & mask_q) == '0) && !rdata_q[bit_q];
	assign take_one = k_q > cnt0_q;
	always_comb begin
		prefix_next = prefix_q;
		prefix_next[bit_q] = take_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_q <= 1'b0;
		end else begin
			scan_v_q <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mean_q <= '0;
			pct_q <= '0;
		end
		if (cmd.mean_store) begin
			mean_q <= div_quot[39:0];
		end
		if (cmd.rate_mul) begin
			num_q <= 50'(count_q - 32'd1) * 50'(RATE_SCALE);
			rate_q <= (count_q < 32'd2) ? '0 : RATE_SAT;
		end
		if (cmd.rate_store) begin
			rate_q <= (div_quot[DIV_NW-1:48] != '0) ? RATE_SAT : div_quot[47:0];
		end
		if (cmd.sel_init) begin
			k_q <= kclamp;
			prefix_q <= '0;
			mask_q <= '0;
			bit_q <= 5'd31;
			cnt0_q <= '0;
			scan_addr_q <= '0;
		end else if (cmd.sel_bit) begin
			if (take_one) k_q <= k_q - cnt0_q;
			prefix_q <= prefix_next;
			mask_q[bit_q] <= 1'b1;
			bit_q <= bit_q - 1'b1;
			cnt0_q <= '0;
			scan_addr_q <= '0;
			if (bit_q == 5'd0) pct_q <= prefix_next;
		end else begin
			if (cmd.scan_rd) scan_addr_q <= scan_addr_q + 1'b1;
			if (scan_v_q && match) cnt0_q <= cnt0_q + 1'b1;
		end
	end

	assign sts.req = req_q;
	assign sts.len_zero = fill_q == '0;
	assign sts.div_done = div_done;
	assign sts.rate_div = (count_q >= 32'd2) && (span != '0);
	assign sts.scan_last = scan_addr_q == AW'(fill_q - 1'b1);
	assign sts.bit_zero = bit_q == 5'd0;

	assign min_value = min_q;
	assign max_value = max_q;
	assign stats_valid = any_q;
	assign sample_count = count_q;
	assign mean_q8 = mean_q;
	assign percentile_value = pct_q;
	assign window_empty = fill_q == '0;
	assign rate_q8 = rate_q;

endmodule

`default_nettype wire

@@ src/latency_window_statistics.sv @@
// ----------------------------------------------------------------------------
// latency_window_statistics
// sliding window latency monitor with all-time min, max, count, rate and
// windowed mean and percentile
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy stays high
// until its result has been shown. The result appears on the output ports for
// exactly one cycle with done high and cannot be held off by the receiver, so
// it must be captured in that cycle. A record updates the ring, then
// uses the shared divider once for the mean and once for the rate; with fewer
// than two records or a zero time span the rate division is skipped. A query
// skips the record update and, on a non-empty window, adds a bit-serial
// select over the window memory at one read per cycle: a setup step plus 32
// passes over the stored samples. A query on an empty window skips both
// divisions and the select.
`default_nettype none
`include "latency_window_statistics_defines.svh"

module latency_window_statistics import lwstat_pkg::*; #(
	parameter int WINDOW = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic [31:0] sample_value,
	input  wire logic [47:0] now_ms,
	input  wire logic [16:0] ratio_q16,
	output logic             done,
	output logic      [31:0] min_value,
	output logic      [31:0] max_value,
	output logic             stats_valid,
	output logic      [31:0] sample_count,
	output logic      [39:0] mean_q8,
	output logic      [31:0] percentile_value,
	output logic             window_empty,
	output logic      [47:0] rate_q8
);

	lwstat_cmd_t    cmd;
	lwstat_status_t sts;

	lwstat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	lwstat_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.req_type         (req_type),
		.sample_value     (sample_value),
		.now_ms           (now_ms),
		.ratio_q16        (ratio_q16),
		.min_value        (min_value),
		.max_value        (max_value),
		.stats_valid      (stats_valid),
		.sample_count     (sample_count),
		.mean_q8          (mean_q8),
		.percentile_value (percentile_value),
		.window_empty     (window_empty),
		.rate_q8          (rate_q8)
	);

	`LWS_ASSERT_NOW(a_done_busy, done, busy)
	`LWS_ASSERT_NEXT(a_done_idle, done, !busy)
	`LWS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`LWS_ASSERT_NOW(a_empty_pct, done && window_empty, percentile_value == '0)
	`LWS_ASSERT_NOW(a_count_valid, done && !stats_valid, sample_count == '0)

endmodule

`default_nettype wire
